FILE: hw/rtl/ipt_pkg.sv
// Shared types, codes and default sizes of the IPv4 prefix trie.
package ipt_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int VALUE_BITS_DEF = 16;
	localparam int ADDR_BITS = 32;
	localparam int PLEN_BITS = 6;
	localparam int ENTRY_BITS = 16;
	localparam int MAX_DEPTH = 32;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic opcode;
		logic [ADDR_BITS-1:0] address;
		logic [PLEN_BITS-1:0] prefix_len;
		logic [ENTRY_BITS-1:0] entry_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ENTRY_BITS-1:0] found_value;
	} rsp_t;

endpackage

FILE: hw/rtl/ipt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ipt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/ipt_walk.sv
// Trie walk engine: lookup and insert sequencer driving the node RAM.
module ipt_walk #(
	parameter int NODE_COUNT = ipt_pkg::NODE_COUNT_DEF,
	parameter int VALUE_BITS = ipt_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input ipt_pkg::cmd_t cmd,
	output logic done,
	input logic res_free,
	output ipt_pkg::rsp_t res,
	output logic mem_wr_en,
	output logic [$clog2(NODE_COUNT)-1:0] mem_wr_addr,
	output logic [2*$clog2(NODE_COUNT)+VALUE_BITS:0] mem_wr_data,
	output logic mem_rd_en,
	output logic [$clog2(NODE_COUNT)-1:0] mem_rd_addr,
	input logic [2*$clog2(NODE_COUNT)+VALUE_BITS:0] mem_rd_data
);

	import ipt_pkg::*;

	localparam int IW = $clog2(NODE_COUNT);
	localparam int NODE_W = 2 * IW + VALUE_BITS + 1;
	localparam int NFW = $clog2(NODE_COUNT + 1);
	localparam int CW = NFW + PLEN_BITS + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD = 2'd1;
	localparam logic [1:0] S_BUILD = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	typedef struct packed {
		logic valid;
		logic [VALUE_BITS-1:0] value;
		logic [IW-1:0] right;
		logic [IW-1:0] left;
	} node_t;

	logic [1:0] state_q, state_d;
	logic [NFW-1:0] nf_q, nf_d;
	logic root_ok_q, root_ok_d;
	logic op_q, op_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic [PLEN_BITS-1:0] plen_q, plen_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [PLEN_BITS-1:0] depth_q, depth_d;
	logic [IW-1:0] idx_q, idx_d;
	node_t node_q, node_d;
	rsp_t res_q, res_d;

	node_t rd_node, wr_node;
	logic [IW-1:0] child;
	logic [VALUE_BITS-1:0] cmd_val;
	logic [ENTRY_BITS-1:0] hit_value;
	logic [CW-1:0] need, room;
	logic full;

	generate
		if (VALUE_BITS <= ENTRY_BITS) begin : g_narrow
			assign cmd_val = cmd.entry_value[VALUE_BITS-1:0];
			assign hit_value = ENTRY_BITS'(rd_node.value);
		end else begin : g_wide
			assign cmd_val = VALUE_BITS'(cmd.entry_value);
			assign hit_value = rd_node.value[ENTRY_BITS-1:0];
		end
	endgenerate

	assign rd_node = (idx_q == '0 && !root_ok_q) ? node_t'('0) : node_t'(mem_rd_data);
	assign child = addr_q[ADDR_BITS-1] ? rd_node.right : rd_node.left;
	assign need = CW'(plen_q) - CW'(depth_q);
	assign room = CW'(NODE_COUNT) - CW'(nf_q);
	assign full = (CW'(nf_q) > CW'(NODE_COUNT)) || (need > room);

	assign cmd_ready = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign res = res_q;
	assign mem_wr_data = NODE_W'(wr_node);

	always_comb begin
		state_d = state_q;
		nf_d = nf_q;
		root_ok_d = root_ok_q;
		op_d = op_q;
		addr_d = addr_q;
		plen_d = plen_q;
		val_d = val_q;
		depth_d = depth_q;
		idx_d = idx_q;
		node_d = node_q;
		res_d = res_q;
		mem_rd_en = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en = 1'b0;
		mem_wr_addr = idx_q;
		wr_node = node_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_d = cmd.opcode;
					addr_d = cmd.address;
					plen_d = (cmd.prefix_len > PLEN_BITS'(MAX_DEPTH)) ?
						PLEN_BITS'(MAX_DEPTH) : cmd.prefix_len;
					val_d = cmd_val;
					depth_d = '0;
					idx_d = '0;
					mem_rd_en = 1'b1;
					mem_rd_addr = '0;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (op_q == OP_LOOKUP) begin
					if (rd_node.valid) begin
						res_d.status = ST_OK;
						res_d.found_value = hit_value;
						state_d = S_DONE;
					end else if (depth_q == PLEN_BITS'(MAX_DEPTH) || child == '0) begin
						res_d.status = ST_MISS;
						res_d.found_value = '0;
						state_d = S_DONE;
					end else begin
						mem_rd_en = 1'b1;
						mem_rd_addr = child;
						idx_d = child;
						depth_d = depth_q + 1'b1;
						addr_d = addr_q << 1;
					end
				end else begin
					if (depth_q < plen_q && child != '0) begin
						mem_rd_en = 1'b1;
						mem_rd_addr = child;
						idx_d = child;
						depth_d = depth_q + 1'b1;
						addr_d = addr_q << 1;
					end else if (full) begin
						res_d.status = ST_FULL;
						res_d.found_value = '0;
						state_d = S_DONE;
					end else begin
						node_d = rd_node;
						state_d = S_BUILD;
					end
				end
			end
			S_BUILD: begin
				mem_wr_en = 1'b1;
				if (idx_q == '0) begin
					root_ok_d = 1'b1;
				end
				if (depth_q < plen_q) begin
					if (addr_q[ADDR_BITS-1]) begin
						wr_node.right = nf_q[IW-1:0];
					end else begin
						wr_node.left = nf_q[IW-1:0];
					end
					node_d = '0;
					idx_d = nf_q[IW-1:0];
					nf_d = nf_q + 1'b1;
					depth_d = depth_q + 1'b1;
					addr_d = addr_q << 1;
				end else begin
					wr_node.valid = 1'b1;
					wr_node.value = val_q;
					res_d.status = ST_OK;
					res_d.found_value = '0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nf_q <= NFW'(1);
			root_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nf_q <= nf_d;
			root_ok_q <= root_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		addr_q <= addr_d;
		plen_q <= plen_d;
		val_q <= val_d;
		depth_q <= depth_d;
		idx_q <= idx_d;
		node_q <= node_d;
		res_q <= res_d;
	end

endmodule

FILE: hw/rtl/ipv4_prefix_trie.sv
// Top level of the IPv4 prefix trie: walk engine, node RAM and result register.
// A lookup reads one node per trie level visited; an insert reads one node per level it
// follows, then writes one node per level from there down to the prefix length.
// One transaction is worked on at a time, so the next can be accepted in the cycle after
// the result enters the output register.
// Reset clears the control state, the root-valid flag and the free pointer; no clearing pass runs.
module ipv4_prefix_trie #(
	parameter int NODE_COUNT = ipt_pkg::NODE_COUNT_DEF,
	parameter int VALUE_BITS = ipt_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input ipt_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_ready,
	output ipt_pkg::rsp_t rsp
);

	import ipt_pkg::*;

	localparam int IW = $clog2(NODE_COUNT);
	localparam int NODE_W = 2 * IW + VALUE_BITS + 1;

	logic done, res_free;
	rsp_t res;
	logic mem_wr_en, mem_rd_en;
	logic [IW-1:0] mem_wr_addr, mem_rd_addr;
	logic [NODE_W-1:0] mem_wr_data, mem_rd_data;
	logic rsp_valid_q;
	rsp_t rsp_q;

	ipt_walk #(
		.NODE_COUNT(NODE_COUNT),
		.VALUE_BITS(VALUE_BITS)
	) u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.done(done),
		.res_free(res_free),
		.res(res),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	ipt_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	assign res_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done && res_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
